// ----- rtl/core/sard_pkg.sv -----
// ----------------------------------------------------------------------------
// sard_pkg
// Shared types, codes and constants of the two-arm servo angle ramp controller.
// ----------------------------------------------------------------------------
package sard_pkg;

  localparam int KIND_W    = 2;
  localparam int ARM_W     = 1;
  localparam int ANGLE_W   = 8;
  localparam int DUR_W     = 16;
  localparam int DUTY_W    = 11;
  localparam int STEPS_W   = 12;
  localparam int EN_W      = 2;
  localparam int ARM_SLOTS = 2;

  localparam int DVD_W     = 20;
  localparam int DVS_W     = STEPS_W;
  localparam int PROD_W    = 23;
  localparam int DIFF_W    = 10;

  localparam logic [KIND_W-1:0]  KIND_SET  = 2'd0;
  localparam logic [KIND_W-1:0]  KIND_MOVE = 2'd1;
  localparam logic [KIND_W-1:0]  KIND_TICK = 2'd2;

  localparam logic [ANGLE_W-1:0] MAX_DEG     = 8'd180;
  localparam logic [ANGLE_W-1:0] NEUTRAL_DEG = 8'd90;
  localparam logic [STEPS_W-1:0] STEPS_MAX   = 12'd4095;

  // duty = 250 + floor(50*angle/9), reciprocal 50*65536/9 rounded up
  localparam logic [DUTY_W-1:0] DUTY_BASE  = 11'd250;
  localparam logic [18:0]       DUTY_RECIP = 19'd364089;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_MOVE  = 3'd1,
    OP_TICK  = 3'd2,
    OP_RANGE = 3'd3,
    OP_OFF   = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [ARM_W-1:0]   arm;
    logic [ANGLE_W-1:0] angle;
    logic [DUR_W-1:0]   dur;
  } cmd_t;

  typedef struct packed {
    logic [ARM_W-1:0]   arm;
    logic [DUTY_W-1:0]  duty;
    logic [ANGLE_W-1:0] angle;
    logic               status;
    logic               moving;
    logic               last;
  } res_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [ANGLE_W-1:0] angle);
    logic [26:0] prod;
    prod = 27'(angle) * 27'(DUTY_RECIP);
    return DUTY_BASE + DUTY_W'(prod[26:16]);
  endfunction

endpackage

// ----- rtl/core/sard_fifo.sv -----
// ----------------------------------------------------------------------------
// sard_fifo
// Small show-ahead register queue used between the stages of the controller.
// ----------------------------------------------------------------------------
module sard_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/sard_front.sv -----
// ----------------------------------------------------------------------------
// sard_front
// Input side: accepts beats, sorts them into commands and queues them.
// ----------------------------------------------------------------------------
module sard_front #(
  parameter int NUM_ARMS = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sard_pkg::EN_W-1:0]      enable,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [sard_pkg::KIND_W-1:0]    in_kind,
  input  logic [sard_pkg::ARM_W-1:0]     in_arm,
  input  logic [sard_pkg::ANGLE_W-1:0]   in_angle,
  input  logic [sard_pkg::DUR_W-1:0]     in_duration_ms,
  input  logic                           cmd_pop,
  output logic                           cmd_empty,
  output sard_pkg::cmd_t                 cmd
);

  sard_pkg::cmd_t cls;
  logic           keep;
  logic [$bits(sard_pkg::cmd_t)-1:0] cmd_bits;

  always_comb begin
    keep      = 1'b1;
    cls.arm   = in_arm;
    cls.angle = in_angle;
    cls.dur   = in_duration_ms;
    cls.op    = sard_pkg::OP_SET;
    case (in_kind)
      sard_pkg::KIND_TICK: begin
        cls.op = sard_pkg::OP_TICK;
      end
      sard_pkg::KIND_SET, sard_pkg::KIND_MOVE: begin
        if (32'(in_arm) >= NUM_ARMS) begin
          cls.op = sard_pkg::OP_RANGE;
        end else if (!enable[in_arm]) begin
          cls.op = sard_pkg::OP_OFF;
        end else if (in_kind == sard_pkg::KIND_SET || in_duration_ms == '0) begin
          cls.op    = sard_pkg::OP_SET;
          cls.angle = (in_angle > sard_pkg::MAX_DEG) ? sard_pkg::MAX_DEG : in_angle;
        end else begin
          cls.op = sard_pkg::OP_MOVE;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  sard_fifo #(
    .W     ($bits(sard_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push && keep),
    .wr_data (cls),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (cmd_bits),
    .empty   (cmd_empty)
  );

  assign cmd = sard_pkg::cmd_t'(cmd_bits);

endmodule

// ----- rtl/core/sard_div.sv -----
// ----------------------------------------------------------------------------
// sard_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sard_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sard_pkg::DVD_W-1:0] dividend,
  input  logic [sard_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [sard_pkg::DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(sard_pkg::DVD_W);

  logic [sard_pkg::DVS_W-1:0] rem_r;
  logic [sard_pkg::DVD_W-1:0] quo_r;
  logic [sard_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [sard_pkg::DVS_W:0]   trial;
  logic [sard_pkg::DVS_W:0]   diff;
  logic                       ge;

  assign trial    = {rem_r, quo_r[sard_pkg::DVD_W-1]};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign diff     = trial - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[sard_pkg::DVS_W-1:0] : trial[sard_pkg::DVS_W-1:0];
      quo_r <= {quo_r[sard_pkg::DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(sard_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/sard_back.sv -----
// ----------------------------------------------------------------------------
// sard_back
// Execution side: arm state, ramp interpolation and result generation.
// ----------------------------------------------------------------------------
module sard_back #(
  parameter int NUM_ARMS = 2,
  parameter int FRAME_MS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sard_pkg::EN_W-1:0] enable,
  input  logic                      cmd_empty,
  input  sard_pkg::cmd_t            cmd,
  output logic                      cmd_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output sard_pkg::res_t            res
);

  localparam int LIVE = (NUM_ARMS < sard_pkg::ARM_SLOTS) ? NUM_ARMS : sard_pkg::ARM_SLOTS;
  localparam int AW   = sard_pkg::ANGLE_W;
  localparam int SW   = sard_pkg::STEPS_W;

  // step count by reciprocal multiply, exact for every 16-bit duration
  localparam int     STEP_SH  = sard_pkg::DUR_W + $clog2(FRAME_MS);
  localparam int     STEP_PW  = sard_pkg::DUR_W + 18;
  localparam longint STEP_RCP = ((longint'(1) << STEP_SH) + longint'(FRAME_MS) - 1)
                                / longint'(FRAME_MS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DISP   = 8'b0000_0010,
    S_SDIV   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DSTART = 8'b0001_0000,
    S_RDIV   = 8'b0010_0000,
    S_PUSH   = 8'b0100_0000,
    S_SCAN   = 8'b1000_0000
  } state_t;

  state_t                            state_r, state_nxt;
  sard_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [sard_pkg::ARM_W-1:0]        cur_r, cur_nxt;
  logic [1:0]                        k_r, k_nxt;
  logic                              tick_r, tick_nxt;
  logic                              last_r, last_nxt;
  logic signed [sard_pkg::PROD_W-1:0] prod_r, prod_nxt;
  sard_pkg::res_t                    res_r, res_nxt;

  logic [AW-1:0] angle_r  [LIVE];
  logic [AW-1:0] angle_nxt[LIVE];
  logic [AW-1:0] start_r  [LIVE];
  logic [AW-1:0] start_nxt[LIVE];
  logic [AW-1:0] target_r  [LIVE];
  logic [AW-1:0] target_nxt[LIVE];
  logic [SW-1:0] steps_r  [LIVE];
  logic [SW-1:0] steps_nxt[LIVE];
  logic [SW-1:0] index_r  [LIVE];
  logic [SW-1:0] index_nxt[LIVE];
  logic [LIVE-1:0] active_r, active_nxt;

  logic                       div_start;
  logic [sard_pkg::DVD_W-1:0] div_dividend;
  logic [sard_pkg::DVS_W-1:0] div_divisor;
  logic                       div_done;
  logic [sard_pkg::DVD_W-1:0] div_quo;

  logic signed [sard_pkg::DIFF_W-1:0] diff;
  logic [sard_pkg::PROD_W-1:0]        mag;
  logic [sard_pkg::DIFF_W-1:0]        qs;
  logic [sard_pkg::DIFF_W-1:0]        point;
  logic [AW-1:0]                      point_c;
  logic [STEP_PW-1:0]                 step_prod;
  logic [sard_pkg::DUR_W-1:0]         step_q;
  logic [SW-1:0]                      steps_c;
  logic                               apply;
  logic                               act;

  sard_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    tick_nxt     = tick_r;
    last_nxt     = last_r;
    prod_nxt     = prod_r;
    res_nxt      = res_r;
    angle_nxt    = angle_r;
    start_nxt    = start_r;
    target_nxt   = target_r;
    steps_nxt    = steps_r;
    index_nxt    = index_r;
    active_nxt   = active_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    diff = $signed({2'b00, target_r[cur_r]}) - $signed({2'b00, start_r[cur_r]});
    mag  = prod_r[sard_pkg::PROD_W-1] ? sard_pkg::PROD_W'(-prod_r)
                                       : sard_pkg::PROD_W'(prod_r);
    qs   = sard_pkg::DIFF_W'(div_quo);
    point = {2'b00, start_r[cur_r]} + (prod_r[sard_pkg::PROD_W-1] ? -qs : qs);
    point_c = (point > sard_pkg::DIFF_W'(sard_pkg::MAX_DEG)) ? sard_pkg::MAX_DEG
                                                            : point[AW-1:0];
    step_prod = STEP_PW'(cmd_r.dur) * STEP_PW'(STEP_RCP);
    step_q    = sard_pkg::DUR_W'(step_prod >> STEP_SH);
    if (step_q == '0) begin
      steps_c = SW'(1);
    end else if (step_q > sard_pkg::DUR_W'(sard_pkg::STEPS_MAX)) begin
      steps_c = sard_pkg::STEPS_MAX;
    end else begin
      steps_c = step_q[SW-1:0];
    end
    apply = !tick_r || enable[cur_r];
    act   = active_r[cur_r];

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        tick_nxt = 1'b0;
        cur_nxt  = cmd_r.arm;
        case (cmd_r.op)
          sard_pkg::OP_RANGE: begin
            res_nxt   = '{cmd_r.arm, '0, sard_pkg::NEUTRAL_DEG, 1'b1, 1'b0, 1'b1};
            state_nxt = S_PUSH;
          end
          sard_pkg::OP_OFF: begin
            res_nxt   = '{cmd_r.arm, '0, angle_r[cmd_r.arm], 1'b1,
                          active_r[cmd_r.arm], 1'b1};
            state_nxt = S_PUSH;
          end
          sard_pkg::OP_SET: begin
            active_nxt[cmd_r.arm] = 1'b0;
            angle_nxt[cmd_r.arm]  = cmd_r.angle;
            res_nxt   = '{cmd_r.arm, '0, cmd_r.angle, 1'b0, 1'b0, 1'b1};
            state_nxt = S_PUSH;
          end
          sard_pkg::OP_MOVE: begin
            state_nxt = S_SDIV;
          end
          sard_pkg::OP_TICK: begin
            tick_nxt  = 1'b1;
            k_nxt     = '0;
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SDIV: begin
        start_nxt[cur_r]  = angle_r[cur_r];
        target_nxt[cur_r] = cmd_r.angle;
        steps_nxt[cur_r]  = steps_c;
        index_nxt[cur_r]  = '0;
        active_nxt[cur_r] = 1'b1;
        state_nxt         = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = $signed(sard_pkg::PROD_W'(diff))
                    * $signed(sard_pkg::PROD_W'(index_r[cur_r]));
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start    = 1'b1;
        div_dividend = sard_pkg::DVD_W'(mag);
        div_divisor  = steps_r[cur_r];
        state_nxt    = S_RDIV;
      end
      S_RDIV: begin
        if (div_done) begin
          if (apply) begin
            angle_nxt[cur_r] = point_c;
          end
          if (tick_r && index_r[cur_r] >= steps_r[cur_r]) begin
            act = 1'b0;
          end
          active_nxt[cur_r] = act;
          res_nxt   = '{cur_r, '0, apply ? point_c : angle_r[cur_r], !apply, act,
                        tick_r ? last_r : 1'b1};
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (tick_r) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (32'(k_r) >= LIVE) begin
          state_nxt = S_IDLE;
        end else if (active_r[k_r[0]]) begin
          cur_nxt = k_r[0];
          if (index_r[k_r[0]] < steps_r[k_r[0]]) begin
            index_nxt[k_r[0]] = index_r[k_r[0]] + 1'b1;
          end
          last_nxt = 1'b1;
          for (int j = 0; j < LIVE; j++) begin
            if (j > 32'(k_r) && active_r[j]) begin
              last_nxt = 1'b0;
            end
          end
          state_nxt = S_MUL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res      = res_r;
    res.duty = sard_pkg::duty_of(res_r.angle);
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    cur_r  <= cur_nxt;
    k_r    <= k_nxt;
    tick_r <= tick_nxt;
    last_r <= last_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
      for (int a = 0; a < LIVE; a++) begin
        angle_r[a]  <= sard_pkg::NEUTRAL_DEG;
        start_r[a]  <= sard_pkg::NEUTRAL_DEG;
        target_r[a] <= '0;
        steps_r[a]  <= SW'(1);
        index_r[a]  <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      angle_r    <= angle_nxt;
      start_r    <= start_nxt;
      target_r   <= target_nxt;
      steps_r    <= steps_nxt;
      index_r    <= index_nxt;
    end
  end

endmodule

// ----- rtl/core/servo_angle_ramp_duty_core.sv -----
// ----------------------------------------------------------------------------
// servo_angle_ramp_duty_core
// Two-arm servo controller: set angle, timed linear move and frame tick items
// in, per-arm duty and angle results out.
// ----------------------------------------------------------------------------
// Items enter a two-deep command queue and are carried out one at a time by
// the execution side, whose cost is set by a 20-step divider used once for
// each ramp point: a set or rejected command is only dispatched and pushed,
// a timed move also takes its step count from a reciprocal multiply and its
// first ramp point from one division, and a tick scans the arms and divides
// once for each arm with a ramp running. A full result queue holds the
// execution side. Results wait in a two-deep output queue, so new items are
// taken while results are unread.
// ----------------------------------------------------------------------------
module servo_angle_ramp_duty_core #(
  parameter int NUM_ARMS = 2,
  parameter int FRAME_MS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sard_pkg::EN_W-1:0]     cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [sard_pkg::KIND_W-1:0]   in_kind,
  input  logic [sard_pkg::ARM_W-1:0]    in_arm,
  input  logic [sard_pkg::ANGLE_W-1:0]  in_angle,
  input  logic [sard_pkg::DUR_W-1:0]    in_duration_ms,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [sard_pkg::ARM_W-1:0]    out_arm,
  output logic [sard_pkg::DUTY_W-1:0]   out_duty,
  output logic [sard_pkg::ANGLE_W-1:0]  out_current_angle,
  output logic                          out_status,
  output logic                          out_moving,
  output logic                          out_last
);

  logic [sard_pkg::EN_W-1:0] cfg_en_r;
  logic                      cmd_pop;
  logic                      cmd_empty;
  sard_pkg::cmd_t            cmd;
  logic                      res_push;
  logic                      res_full;
  sard_pkg::res_t            res;
  logic [$bits(sard_pkg::res_t)-1:0] head_bits;
  sard_pkg::res_t            head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r <= '1;
    end else if (cfg_we) begin
      cfg_en_r <= cfg_wdata;
    end
  end

  sard_front #(
    .NUM_ARMS (NUM_ARMS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .enable         (cfg_en_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_arm         (in_arm),
    .in_angle       (in_angle),
    .in_duration_ms (in_duration_ms),
    .cmd_pop        (cmd_pop),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd)
  );

  sard_back #(
    .NUM_ARMS (NUM_ARMS),
    .FRAME_MS (FRAME_MS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (cfg_en_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result beats
  sard_fifo #(
    .W     ($bits(sard_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (head_bits),
    .empty   (out_empty)
  );

  assign head              = sard_pkg::res_t'(head_bits);
  assign out_arm           = head.arm;
  assign out_duty          = head.duty;
  assign out_current_angle = head.angle;
  assign out_status        = head.status;
  assign out_moving        = head.moving;
  assign out_last          = head.last;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-arm servo angle ramp controller. Commands
// and frame ticks go in through the input queue. A predictor in the
// scoreboard keeps its own arm angles, ramps and enable mask, and works out
// the duty beats that each accepted item should cause. Every popped beat is
// compared field by field with the oldest expected beat. Both sides idle at
// random. Twice the receiver holds off long enough for the block to fill up
// and stall its input. The channel enable mask is changed only while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import sard_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int FRAME_MS     = 20;
  localparam int CLK_HALF     = 6;
  localparam int SETTLE       = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 275;
  localparam int LIMIT_CYCLES = 1_000_000;

  class servo_scoreboard;
    logic [EN_W-1:0]    enable;
    logic [ANGLE_W-1:0] arm_angle [ARM_SLOTS];
    logic [ANGLE_W-1:0] ramp_from [ARM_SLOTS];
    logic [ANGLE_W-1:0] ramp_to   [ARM_SLOTS];
    logic [STEPS_W-1:0] ramp_len  [ARM_SLOTS];
    logic [STEPS_W-1:0] ramp_pos  [ARM_SLOTS];
    bit                 ramp_on   [ARM_SLOTS];
    res_t               duty_q[$];
    int                 errors;
    int                 beats;

    function new();
      enable = 2'd3;
      for (int k = 0; k < ARM_SLOTS; k++) begin
        arm_angle[k] = NEUTRAL_DEG;
        ramp_from[k] = NEUTRAL_DEG;
        ramp_to[k]   = '0;
        ramp_len[k]  = 12'd1;
        ramp_pos[k]  = '0;
        ramp_on[k]   = 1'b0;
      end
      errors = 0;
      beats  = 0;
    endfunction

    function int pending();
      return duty_q.size();
    endfunction

    function logic [DUTY_W-1:0] pulse_width(logic [ANGLE_W-1:0] ang);
      int a;
      a = (ang > MAX_DEG) ? MAX_DEG : ang;
      return DUTY_W'((2250 + 50 * a) / 9);
    endfunction

    // linear interpolation, truncated toward zero, then clamped
    function logic [ANGLE_W-1:0] ramp_value(int k);
      int s, t, i, n, v;
      s = ramp_from[k];
      t = ramp_to[k];
      i = ramp_pos[k];
      n = (ramp_len[k] == 0) ? 1 : ramp_len[k];
      v = s + (t - s) * i / n;
      if (v < 0) v = 0;
      if (v > MAX_DEG) v = MAX_DEG;
      return ANGLE_W'(v);
    endfunction

    function void expect_beat(int k, logic st, logic mv, logic fin);
      res_t r;
      r.arm    = ARM_W'(k);
      r.duty   = pulse_width(arm_angle[k]);
      r.angle  = arm_angle[k];
      r.status = st;
      r.moving = mv;
      r.last   = fin;
      duty_q.push_back(r);
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [ARM_W-1:0] arm,
                            logic [ANGLE_W-1:0] ang, logic [DUR_W-1:0] ms);
      int   n, steps;
      logic st;
      res_t r;
      if (kind == KIND_TICK) begin
        n = 0;
        for (int k = 0; k < ARM_SLOTS; k++) begin
          if (!ramp_on[k]) continue;
          if (ramp_pos[k] < ramp_len[k]) ramp_pos[k]++;
          st = 1'b1;
          if (enable[k]) begin
            arm_angle[k] = ramp_value(k);
            st = 1'b0;
          end
          if (ramp_pos[k] >= ramp_len[k]) ramp_on[k] = 1'b0;
          expect_beat(k, st, ramp_on[k], 1'b0);
          n++;
        end
        if (n > 0) begin
          r = duty_q.pop_back();
          r.last = 1'b1;
          duty_q.push_back(r);
        end
      end else if (kind == KIND_NOP) begin
        return;
      end else if (!enable[arm]) begin
        expect_beat(arm, 1'b1, ramp_on[arm], 1'b1);
      end else if (kind == KIND_SET || ms == 0) begin
        ramp_on[arm]   = 1'b0;
        arm_angle[arm] = (ang > MAX_DEG) ? MAX_DEG : ang;
        expect_beat(arm, 1'b0, 1'b0, 1'b1);
      end else begin
        steps = ms / FRAME_MS;
        if (steps == 0) steps = 1;
        if (steps > STEPS_MAX) steps = STEPS_MAX;
        ramp_from[arm] = arm_angle[arm];
        ramp_to[arm]   = ang;
        ramp_len[arm]  = STEPS_W'(steps);
        ramp_pos[arm]  = '0;
        ramp_on[arm]   = 1'b1;
        arm_angle[arm] = ramp_value(arm);
        expect_beat(arm, 1'b0, 1'b1, 1'b1);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at beat %0d: %s", beats, msg);
    endtask

    task check_beat(logic [ARM_W-1:0] arm, logic [DUTY_W-1:0] duty,
                    logic [ANGLE_W-1:0] ang, logic st, logic mv, logic fin);
      res_t w;
      beats++;
      if (duty_q.size() == 0) begin
        report("beat arrived with nothing expected");
        return;
      end
      w = duty_q.pop_front();
      if (arm !== w.arm)     report($sformatf("arm %0d, want %0d", arm, w.arm));
      if (duty !== w.duty)   report($sformatf("duty %0d, want %0d", duty, w.duty));
      if (ang !== w.angle)   report($sformatf("angle %0d, want %0d", ang, w.angle));
      if (st !== w.status)   report($sformatf("status %0d, want %0d", st, w.status));
      if (mv !== w.moving)   report($sformatf("moving %0d, want %0d", mv, w.moving));
      if (fin !== w.last)    report($sformatf("last %0d, want %0d", fin, w.last));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [EN_W-1:0]     cfg_wdata;
  logic                in_push;
  logic                in_full;
  logic [KIND_W-1:0]   in_kind;
  logic [ARM_W-1:0]    in_arm;
  logic [ANGLE_W-1:0]  in_angle;
  logic [DUR_W-1:0]    in_duration_ms;
  logic                out_empty;
  logic                out_pop;
  logic [ARM_W-1:0]    out_arm;
  logic [DUTY_W-1:0]   out_duty;
  logic [ANGLE_W-1:0]  out_current_angle;
  logic                out_status;
  logic                out_moving;
  logic                out_last;

  servo_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_req;
  logic [EN_W-1:0] phase_en [0:5] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd3};

  servo_angle_ramp_duty_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_arm            (in_arm),
    .in_angle          (in_angle),
    .in_duration_ms    (in_duration_ms),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_arm           (out_arm),
    .out_duty          (out_duty),
    .out_current_angle (out_current_angle),
    .out_status        (out_status),
    .out_moving        (out_moving),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("servo_angle_ramp_duty_core test failed");
    $finish;
  end

  // receiver: checks popped beats, idles at random, holds off on request
  initial begin
    out_pop <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty)
        sb.check_beat(out_arm, out_duty, out_current_angle, out_status, out_moving,
                      out_last);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind, logic [ARM_W-1:0] arm,
                           logic [ANGLE_W-1:0] ang, logic [DUR_W-1:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_kind        <= kind;
    in_arm         <= arm;
    in_angle       <= ang;
    in_duration_ms <= ms;
    do @(posedge clk); while (in_full);
    sb.note_item(kind, arm, ang, ms);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable(logic [EN_W-1:0] mask);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.enable = mask;
  endtask

  function automatic logic [DUR_W-1:0] ramp_ms();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DUR_W'($urandom_range(1, 19));
      2:       return DUR_W'($urandom_range(0, 65535));
      default: return DUR_W'($urandom_range(20, 200));
    endcase
  endfunction

  // mostly a move followed by ticks, now and then a command on the other arm
  task automatic run_phase(int count);
    int                sent, ticks;
    logic [ARM_W-1:0]  side;
    logic [DUR_W-1:0]  ms;
    logic [KIND_W-1:0] kind;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 75) begin
        side = ARM_W'($urandom_range(1));
        ms   = ramp_ms();
        send_item(KIND_MOVE, side, ANGLE_W'($urandom_range(255)), ms);
        sent++;
        ticks = $urandom_range(ms / FRAME_MS + 2);
        if (ticks > 12) ticks = 12;
        repeat (ticks) begin
          if ($urandom_range(7) == 0)
            send_item($urandom_range(1) ? KIND_MOVE : KIND_SET, ~side,
                      ANGLE_W'($urandom_range(255)), ramp_ms());
          else
            send_item(KIND_TICK, ARM_W'($urandom_range(1)),
                      ANGLE_W'($urandom_range(255)), DUR_W'($urandom));
          sent++;
        end
      end else begin
        kind = KIND_W'($urandom_range(3));
        send_item(kind, ARM_W'($urandom_range(1)), ANGLE_W'($urandom_range(255)),
                  DUR_W'($urandom));
        if (kind != KIND_NOP) sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_push        <= 1'b0;
    in_kind        <= KIND_SET;
    in_arm         <= '0;
    in_angle       <= '0;
    in_duration_ms <= '0;
    hold_req      = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 59;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_enable(2'd3);

    // extremes, clamping, direct moves, idle ticks, ignored kind
    send_item(KIND_SET,  1'b0, 8'd0,   16'd0);
    send_item(KIND_SET,  1'b1, 8'd180, 16'hffff);
    send_item(KIND_SET,  1'b0, 8'd255, 16'd0);
    send_item(KIND_MOVE, 1'b1, 8'd0,   16'd0);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);
    send_item(KIND_NOP,  1'b1, 8'd255, 16'hffff);
    // target above the clamp, single step ramp, both arms on one tick
    send_item(KIND_MOVE, 1'b0, 8'd255, 16'd60);
    send_item(KIND_MOVE, 1'b1, 8'd90,  16'd19);
    send_item(KIND_TICK, 1'b1, 8'd0,   16'd0);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);
    // new command replaces a running ramp
    send_item(KIND_SET,  1'b0, 8'd45,  16'd0);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);
    send_item(KIND_MOVE, 1'b1, 8'd0,   16'hffff);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);
    send_item(KIND_MOVE, 1'b0, 8'd200, 16'd40);
    wait_idle();

    // right arm disabled with its ramp still running
    write_enable(2'd1);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);
    send_item(KIND_SET,  1'b1, 8'd30,  16'd0);
    send_item(KIND_MOVE, 1'b1, 8'd170, 16'd100);
    send_item(KIND_TICK, 1'b1, 8'd0,   16'd0);
    wait_idle();
    write_enable(2'd0);
    send_item(KIND_SET,  1'b0, 8'd10,  16'd0);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);
    wait_idle();
    write_enable(2'd2);
    send_item(KIND_MOVE, 1'b0, 8'd120, 16'd100);
    send_item(KIND_SET,  1'b1, 8'd100, 16'd0);
    send_item(KIND_TICK, 1'b0, 8'd0,   16'd0);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_enable(phase_en[p]);
      if (p < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 59;
      end else if (p < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 2 || p == 5) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end
    wait_idle();

    if (sb.errors == 0)
      $display("servo_angle_ramp_duty_core test passed");
    else
      $display("servo_angle_ramp_duty_core test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sard_pkg.sv
rtl/core/sard_fifo.sv
rtl/core/sard_front.sv
rtl/core/sard_div.sv
rtl/core/sard_back.sv
rtl/core/servo_angle_ramp_duty_core.sv
tb/sv/tb_top.sv
